### rtl/caif_pkg.sv
// Shared constants, types and codes for the clause argument index filter.
`timescale 1ns / 1ps

package caif_pkg;

    localparam int MAX_CLAUSES = 64;
    localparam int ARGS        = 4;
    localparam int KEY_BITS    = 32;

    localparam int CLS_W = $clog2(MAX_CLAUSES);
    localparam int POS_W = (ARGS > 1) ? $clog2(ARGS) : 1;

    // Command queue between front and back; the depth is a power of two so that
    // the pointers wrap naturally.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Fixed field widths of the stream ports.
    localparam int CMD_W       = 2;
    localparam int CLAUSE_W    = 6;
    localparam int ARGPOS_W    = 2;
    localparam int KEYWORD_W   = 32;
    localparam int KIND_W      = 2;
    localparam int IN_DATA_W   = 40;
    localparam int IN_USER_W   = 4;
    localparam int OUT_DATA_W  = 8;
    localparam int OUT_USER_W  = 1;

    localparam logic [CMD_W-1:0] CMD_CLAUSE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    typedef enum logic [1:0] {
        KIND_KEY = 2'd0,
        KIND_VAR = 2'd1,
        KIND_END = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CLAUSE,
        OP_QUERY,
        OP_RUN,
        OP_CLEAR
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        t_op                 op;
        logic [CLS_W-1:0]    clause;
        logic [POS_W-1:0]    pos;
        logic [KEY_BITS-1:0] key;
        logic                is_key;
        t_kind               qkind;
    } t_item;

endpackage

### rtl/caif_front.sv
// Front part: accepts input transactions, classifies them and queues them for the back part.
`timescale 1ns / 1ps

module caif_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tvalid,
    output logic                          o_tready,
    input  logic [caif_pkg::IN_DATA_W-1:0] i_tdata,
    input  logic [caif_pkg::IN_USER_W-1:0] i_tuser,
    output caif_pkg::t_item               o_item,
    output logic                          o_item_valid,
    input  logic                          i_pop
);
    import caif_pkg::*;

    t_item             r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    logic [CMD_W-1:0]  cmd;
    logic [KIND_W-1:0] raw_kind;
    logic [7:0]        clause_ext;
    logic [7:0]        pos_ext;
    logic [63:0]       key_ext;
    t_item             item;
    logic              push;
    logic              pop;

    always_comb begin
        cmd        = i_tuser[1:0];
        raw_kind   = i_tuser[3:2];
        clause_ext = 8'(i_tdata[5:0]);
        pos_ext    = 8'(i_tdata[7:6]);
        key_ext    = 64'(i_tdata[39:8]);

        item.clause = clause_ext[CLS_W-1:0];
        item.pos    = pos_ext[POS_W-1:0];
        item.key    = key_ext[KEY_BITS-1:0];
        item.is_key = (raw_kind == KIND_KEY);
        if (raw_kind == KIND_KEY) begin
            item.qkind = KIND_KEY;
        end else if (raw_kind == KIND_VAR) begin
            item.qkind = KIND_VAR;
        end else begin
            item.qkind = KIND_END;
        end

        // Out-of-range slot or position writes are dropped here.
        case (cmd)
            CMD_CLAUSE: item.op = (clause_ext < 8'(MAX_CLAUSES) && pos_ext < 8'(ARGS))
                                  ? OP_CLAUSE : OP_NOP;
            CMD_QUERY:  item.op = (pos_ext < 8'(ARGS)) ? OP_QUERY : OP_NOP;
            CMD_RUN:    item.op = OP_RUN;
            CMD_CLEAR:  item.op = OP_CLEAR;
            default:    item.op = OP_NOP;
        endcase
    end

    assign o_tready     = (r_cnt != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign push         = i_tvalid && o_tready;
    assign o_item_valid = (r_cnt != '0);
    assign pop          = i_pop && o_item_valid;
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + (QPTR_W + 1)'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

### rtl/caif_back.sv
// Back part: clause table, query vector, scan pipeline and result register.
`timescale 1ns / 1ps

module caif_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_wdata,
    input  caif_pkg::t_item                i_item,
    input  logic                           i_item_valid,
    output logic                           o_pop,
    output logic                           o_tvalid,
    input  logic                           i_tready,
    output logic [caif_pkg::OUT_DATA_W-1:0] o_tdata,
    output logic [caif_pkg::OUT_USER_W-1:0] o_tuser,
    output logic                           o_tlast
);
    import caif_pkg::*;

    // Table state: one key memory per argument lane, key-present and slot-valid flops.
    logic [ARGS-1:0]     r_keyset [MAX_CLAUSES];
    logic [MAX_CLAUSES-1:0] r_cvalid;
    logic [KEY_BITS-1:0] r_qkey [ARGS];
    t_kind               r_qkind [ARGS];
    logic                r_en;

    // Sequencer and scan pipeline.
    t_state              r_state, n_state;
    logic [CLS_W-1:0]    r_addr, n_addr;
    logic                r_issue_done, n_issue_done;
    logic                r_b_valid, n_b_valid;
    logic [CLS_W-1:0]    r_b_clause, n_b_clause;
    logic                r_b_cvalid;
    logic [ARGS-1:0]     r_b_keyset;
    logic [KEY_BITS-1:0] r_rd [ARGS];
    logic                r_pend_valid, n_pend_valid;
    logic [CLS_W-1:0]    r_pend, n_pend;

    // Result register.
    logic                r_out_valid, n_out_valid;
    logic [CLS_W-1:0]    r_out_clause, n_out_clause;
    logic                r_out_none, n_out_none;
    logic                r_out_last, n_out_last;

    logic                do_clause;
    logic                do_query;
    logic                do_clear;
    logic                rd_en;
    logic                out_free;
    logic                advance;
    logic                b_match;
    logic [ARGS-1:0]     q_live;
    logic [ARGS-1:0]     mismatch;
    logic                live;

    assign out_free = !r_out_valid || i_tready;

    // A query position counts only when it is a key before the first end mark.
    always_comb begin
        live = 1'b1;
        for (int p = 0; p < ARGS; p++) begin
            if (r_qkind[p] == KIND_END) begin
                live = 1'b0;
            end
            q_live[p]   = live && (r_qkind[p] == KIND_KEY);
            mismatch[p] = q_live[p] && r_b_keyset[p] && (r_rd[p] != r_qkey[p]);
        end
        b_match = r_b_cvalid && (!r_en || (mismatch == '0));
    end

    // The pipe holds while a second match would need the busy result register.
    assign advance = !(r_b_valid && b_match && r_pend_valid && !out_free);
    assign rd_en   = (r_state == ST_SCAN) && advance && !r_issue_done;

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_issue_done = r_issue_done;
        n_b_valid    = r_b_valid;
        n_b_clause   = r_b_clause;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid;
        n_out_clause = r_out_clause;
        n_out_none   = r_out_none;
        n_out_last   = r_out_last;
        o_pop        = 1'b0;
        do_clause    = 1'b0;
        do_query     = 1'b0;
        do_clear     = 1'b0;

        if (r_out_valid && i_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_pop = 1'b1;
                    case (i_item.op)
                        OP_CLAUSE: do_clause = 1'b1;
                        OP_QUERY:  do_query  = 1'b1;
                        OP_CLEAR:  do_clear  = 1'b1;
                        OP_RUN: begin
                            n_state      = ST_SCAN;
                            n_addr       = '0;
                            n_issue_done = 1'b0;
                            n_b_valid    = 1'b0;
                            n_pend_valid = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (advance) begin
                    n_b_valid  = !r_issue_done;
                    n_b_clause = r_addr;
                    if (!r_issue_done) begin
                        if (r_addr == CLS_W'(MAX_CLAUSES - 1)) begin
                            n_issue_done = 1'b1;
                        end else begin
                            n_addr = r_addr + CLS_W'(1);
                        end
                    end
                    if (r_b_valid && b_match) begin
                        if (r_pend_valid) begin
                            n_out_valid  = 1'b1;
                            n_out_clause = r_pend;
                            n_out_none   = 1'b0;
                            n_out_last   = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend       = r_b_clause;
                    end
                    if (r_b_valid && r_b_clause == CLS_W'(MAX_CLAUSES - 1)) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_clause = r_pend_valid ? r_pend : '0;
                    n_out_none   = !r_pend_valid;
                    n_out_last   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_issue_done <= 1'b0;
            r_b_valid    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_issue_done <= n_issue_done;
            r_b_valid    <= n_b_valid;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_b_clause   <= n_b_clause;
        r_pend       <= n_pend;
        r_out_clause <= n_out_clause;
        r_out_none   <= n_out_none;
        r_out_last   <= n_out_last;
        if (rd_en) begin
            r_b_cvalid <= r_cvalid[r_addr];
            r_b_keyset <= r_keyset[r_addr];
        end
    end

    // Key memories, one per argument lane, read one clause row per scan cycle while the pipe advances.
    for (genvar g = 0; g < ARGS; g++) begin : g_lane
        logic [KEY_BITS-1:0] mem [MAX_CLAUSES];

        always_ff @(posedge i_clk) begin
            if (do_clause && i_item.is_key && i_item.pos == POS_W'(g)) begin
                mem[i_item.clause] <= i_item.key;
            end
            if (rd_en) begin
                r_rd[g] <= mem[r_addr];
            end
        end
    end

    // The first write to a slot after reset or a clear rebuilds its whole row with
    // variable marks elsewhere, so a clear only has to drop the valid flags.
    always_ff @(posedge i_clk) begin
        if (do_clause) begin
            if (r_cvalid[i_item.clause]) begin
                r_keyset[i_item.clause][i_item.pos] <= i_item.is_key;
            end else begin
                r_keyset[i_item.clause] <= ARGS'(i_item.is_key) << i_item.pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
            for (int p = 0; p < ARGS; p++) begin
                r_qkey[p]  <= '0;
                r_qkind[p] <= KIND_END;
            end
            r_en <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_en <= i_cfg_wdata;
            end
            if (do_clear) begin
                r_cvalid <= '0;
            end
            if (do_clause) begin
                r_cvalid[i_item.clause] <= 1'b1;
            end
            if (do_query) begin
                r_qkey[i_item.pos]  <= i_item.key;
                r_qkind[i_item.pos] <= i_item.qkind;
            end
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = OUT_DATA_W'(r_out_clause);
    assign o_tuser  = r_out_none;
    assign o_tlast  = r_out_last;

endmodule

### rtl/clause_argument_index_filter_top.sv
// Top level of the clause argument index filter: front classifier, queue and back scanner.
`timescale 1ns / 1ps

// The block holds a table of 64 clause slots with four argument positions each, every
// position either a 32-bit key or a variable mark, plus a four-position query vector.
// Each input transaction carries one command: store one clause entry, store one query
// entry, run the query, or clear the table. Store and clear commands produce no output.
// A run scans every slot in ascending order through the per-position key memories, one
// slot per clock while the output side keeps up, comparing all positions in parallel.
// A run emits one transaction per matching clause with tlast on the final one, or a
// single transaction with the none-found flag set and clause 0 when nothing matches. A
// two-entry command queue lets new commands be accepted while a run is still in
// progress, and the result register lets the scan continue while the previous result
// waits to be taken. The index_enable register resets to 1; writing 0 makes every valid
// clause match. The user must write it only while the block is idle; the block itself
// does not enforce this. No clearing pass follows reset.

module clause_argument_index_filter_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [5:0] clause_number, [7:6] arg_position, [39:8] key_word
    input  logic [caif_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] cmd, [3:2] entry_kind
    input  logic [caif_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [5:0] match_clause, [7:6] zero
    output logic [caif_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] none_found
    output logic [caif_pkg::OUT_USER_W-1:0] m_axis_tuser,
    output logic                            m_axis_tlast
);
    import caif_pkg::*;

    t_item item;
    logic  item_valid;
    logic  pop;

    // The front decodes commands and drops out-of-range writes before queueing.
    caif_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tvalid     (s_axis_tvalid),
        .o_tready     (s_axis_tready),
        .i_tdata      (s_axis_tdata),
        .i_tuser      (s_axis_tuser),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_pop        (pop)
    );

    // The back owns all table state and the result register.
    caif_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_pop        (pop),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata),
        .o_tuser      (m_axis_tuser),
        .o_tlast      (m_axis_tlast)
    );

endmodule

### rtl/caif_checker.sv
// Port-level checker for the clause argument index filter and its bind statement.
`timescale 1ns / 1ps

module caif_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [caif_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [caif_pkg::OUT_USER_W-1:0] m_axis_tuser,
    input logic                            m_axis_tlast
);
    import caif_pkg::*;

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // An empty run ends with its single result.
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("none-found result without tlast");

    // An empty run reports clause zero.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("none-found result with nonzero clause");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind clause_argument_index_filter_top caif_checker u_caif_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### tb/tb.sv
// Self-checking testbench for the clause argument index filter top level.
`timescale 1ns / 1ps

module tb;
    import caif_pkg::*;

    // Query kind code without a name of its own; the block treats it as an end mark
    // in a query and as a variable mark in a clause entry.
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    // Settling time for a run, with room for a queued command on top.
    localparam int SETTLE_CYCLES = 90;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;

    typedef struct {
        logic [CLAUSE_W-1:0] clause;
        logic                none;
        logic                last;
    } t_clause_hit;

    // Keeps its own copy of the clause table and query vector, works out which clauses
    // each run transaction must report, and compares the output transactions in order.
    class t_match_scoreboard;
        logic [KEY_BITS-1:0] slot_key [MAX_CLAUSES][ARGS];
        bit                  slot_var [MAX_CLAUSES][ARGS];
        bit                  slot_valid [MAX_CLAUSES];
        logic [KEY_BITS-1:0] query_key [ARGS];
        t_kind               query_kind [ARGS];
        bit                  index_on;
        t_clause_hit         expected_hits [$];
        int                  errors;

        function new();
            for (int c = 0; c < MAX_CLAUSES; c++) begin
                slot_valid[c] = 1'b0;
                for (int p = 0; p < ARGS; p++) begin
                    slot_key[c][p] = '0;
                    slot_var[c][p] = 1'b1;
                end
            end
            for (int p = 0; p < ARGS; p++) begin
                query_key[p]  = '0;
                query_kind[p] = KIND_END;
            end
            index_on = 1'b1;
            errors   = 0;
        endfunction

        // A clause passes when the index is off or when every keyed query position ahead of the
        // first end mark meets a variable mark or an equal key.
        function bit clause_hit(int c);
            if (!index_on)
                return 1'b1;
            for (int p = 0; p < ARGS; p++) begin
                if (query_kind[p] == KIND_END)
                    return 1'b1;
                if (query_kind[p] == KIND_KEY && !slot_var[c][p]
                        && slot_key[c][p] != query_key[p])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [CLAUSE_W-1:0] cls,
                                   logic [ARGPOS_W-1:0] pos, logic [KEYWORD_W-1:0] key,
                                   logic [KIND_W-1:0] kind);
            t_clause_hit hit;
            int          found;
            found = 0;
            case (cmd)
                CMD_CLAUSE: begin
                    if (kind == KIND_KEY) begin
                        slot_key[cls][pos] = key;
                        slot_var[cls][pos] = 1'b0;
                    end else begin
                        slot_var[cls][pos] = 1'b1;
                    end
                    slot_valid[cls] = 1'b1;
                end
                CMD_QUERY: begin
                    query_key[pos]  = key;
                    query_kind[pos] = (kind >= KIND_END) ? KIND_END : t_kind'(kind);
                end
                CMD_RUN: begin
                    for (int c = 0; c < MAX_CLAUSES; c++) begin
                        if (slot_valid[c] && clause_hit(c)) begin
                            hit.clause = CLAUSE_W'(c);
                            hit.none   = 1'b0;
                            hit.last   = 1'b0;
                            expected_hits.push_back(hit);
                            found++;
                        end
                    end
                    if (found == 0) begin
                        hit.clause = '0;
                        hit.none   = 1'b1;
                        hit.last   = 1'b1;
                        expected_hits.push_back(hit);
                    end else begin
                        expected_hits[expected_hits.size() - 1].last = 1'b1;
                    end
                end
                default: begin
                    // Clearing keeps the query vector and the register.
                    for (int c = 0; c < MAX_CLAUSES; c++) begin
                        slot_valid[c] = 1'b0;
                        for (int p = 0; p < ARGS; p++)
                            slot_var[c][p] = 1'b1;
                    end
                end
            endcase
        endfunction

        function void check_result(logic [CLAUSE_W-1:0] cls, logic none, logic last);
            t_clause_hit want;
            if (expected_hits.size() == 0) begin
                $error("unexpected result: match_clause %0d none_found %0b last %0b",
                       cls, none, last);
                errors++;
                return;
            end
            want = expected_hits.pop_front();
            if (cls !== want.clause) begin
                $error("match_clause: expected %0d, actual %0d", want.clause, cls);
                errors++;
            end
            if (none !== want.none) begin
                $error("none_found: expected %0b, actual %0b", want.none, none);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_wdata = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;

    t_match_scoreboard results;
    int  feed_gap_pct  = 0;
    int  sink_stall_pct = 0;
    bit  hold_request  = 1'b0;
    int  hold_left     = 0;
    int  quiet_cycles  = 0;

    always #5 i_clk = ~i_clk;

    clause_argument_index_filter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    // Output side: random stalls, plus a long hold-off on request so that the block
    // backs up and refuses input for a while.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Results are checked before the input of the same edge is noted; a result can
    // never belong to a command accepted at that very edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready)
                results.check_result(m_tdata[CLAUSE_W-1:0], m_tuser[0], m_tlast);
            if (s_tvalid && s_tready)
                results.note_command(s_tuser[1:0], s_tdata[5:0], s_tdata[7:6],
                                     s_tdata[39:8], s_tuser[3:2]);
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_command(input logic [CMD_W-1:0] cmd, input logic [CLAUSE_W-1:0] cls,
                                input logic [ARGPOS_W-1:0] pos,
                                input logic [KEYWORD_W-1:0] key,
                                input logic [KIND_W-1:0] kind);
        while ($urandom_range(99) < feed_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {key, pos, cls};
        s_tuser  <= {kind, cmd};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Stops offering input until every expected result has arrived and any trailing
    // store or clear has had time to leave the block.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results.expected_hits.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_index_enable(input logic value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        results.index_on = value;
    endtask

    function automatic logic [KEYWORD_W-1:0] pool_key(int i);
        case (i)
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0001;
            default: return 32'h1234_5678;
        endcase
    endfunction

    // Keys come mostly from a small pool so that stored keys and query keys meet often.
    task automatic random_command();
        logic [CMD_W-1:0]     cmd;
        logic [CLAUSE_W-1:0]  cls;
        logic [ARGPOS_W-1:0]  pos;
        logic [KEYWORD_W-1:0] key;
        logic [KIND_W-1:0]    kind;
        int                   pick;
        pick = $urandom_range(99);
        if (pick < 45)
            cmd = CMD_CLAUSE;
        else if (pick < 70)
            cmd = CMD_QUERY;
        else if (pick < 97)
            cmd = CMD_RUN;
        else
            cmd = CMD_CLEAR;
        cls = CLAUSE_W'($urandom_range(MAX_CLAUSES - 1));
        pos = ARGPOS_W'($urandom_range(ARGS - 1));
        key = ($urandom_range(3) == 0) ? $urandom() : pool_key($urandom_range(3));
        pick = $urandom_range(9);
        if (cmd == CMD_QUERY) begin
            if (pick < 5)
                kind = KIND_KEY;
            else if (pick < 8)
                kind = KIND_VAR;
            else if (pick < 9)
                kind = KIND_END;
            else
                kind = KIND_SPARE;
        end else begin
            kind = (pick < 7) ? KIND_KEY : KIND_W'($urandom_range(3, 1));
        end
        push_command(cmd, cls, pos, key, kind);
    endtask

    initial begin
        int enable_now;
        results = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        feed_gap_pct   = 29;
        sink_stall_pct = 88;

        // Directed part, with the register at its reset value. An empty table gives
        // the none-found result.
        push_command(CMD_RUN, '0, '0, '0, KIND_KEY);
        push_command(CMD_CLAUSE, 6'd0, 2'd0, 32'h0000_0000, KIND_KEY);
        push_command(CMD_CLAUSE, 6'd63, 2'd3, 32'hFFFF_FFFF, KIND_KEY);
        push_command(CMD_CLAUSE, 6'd5, 2'd1, 32'hDEAD_BEEF, KIND_VAR);
        push_command(CMD_CLAUSE, 6'd7, 2'd2, 32'h0000_0000, KIND_END);
        push_command(CMD_CLAUSE, 6'd9, 2'd0, 32'hFFFF_FFFF, KIND_SPARE);
        // The reset query is all end marks, so every valid clause matches.
        push_command(CMD_RUN, '0, '0, '0, KIND_KEY);
        push_command(CMD_QUERY, '0, 2'd0, 32'h1234_5678, KIND_KEY);
        push_command(CMD_QUERY, '0, 2'd1, 32'h0000_0000, KIND_VAR);
        push_command(CMD_QUERY, '0, 2'd2, 32'hFFFF_FFFF, KIND_VAR);
        push_command(CMD_QUERY, '0, 2'd3, 32'hFFFF_FFFF, KIND_KEY);
        // Clause 0 fails on its first key; clause 63 meets an equal key.
        push_command(CMD_RUN, '0, '0, '0, KIND_KEY);
        push_command(CMD_QUERY, '0, 2'd3, 32'h0000_0000, KIND_KEY);
        push_command(CMD_RUN, '0, '0, '0, KIND_KEY);
        // An end mark in front makes every later position a wildcard.
        push_command(CMD_QUERY, '0, 2'd0, 32'h0000_0000, KIND_SPARE);
        push_command(CMD_RUN, '0, '0, '0, KIND_KEY);
        push_command(CMD_QUERY, '0, 2'd0, 32'h0000_0000, KIND_END);
        push_command(CMD_RUN, '0, '0, '0, KIND_KEY);
        push_command(CMD_CLEAR, '0, '0, '0, KIND_KEY);
        push_command(CMD_RUN, '0, '0, '0, KIND_KEY);
        drain();

        // Three idling patterns, each with the filter off and then on.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    feed_gap_pct   = 29;
                    sink_stall_pct = 88;
                end
                1: begin
                    feed_gap_pct   = 88;
                    sink_stall_pct = 29;
                end
                default: begin
                    feed_gap_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            for (int half = 0; half < 2; half++) begin
                enable_now = half;
                set_index_enable(enable_now[0]);
                if (phase == 2 && half == 1)
                    hold_request = 1'b1;
                repeat (half == 0 ? 40 : 95) random_command();
                drain();
            end
        end

        if (results.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
rtl/caif_pkg.sv
rtl/caif_front.sv
rtl/caif_back.sv
rtl/clause_argument_index_filter_top.sv
rtl/caif_checker.sv
tb/tb.sv
